[hdl/spmcd_pkg.sv]
`timescale 1ns / 1ps
package spmcd_pkg;

  localparam int MapWidthDef  = 512;
  localparam int MapHeightDef = 512;
  localparam int MaxRadiusDef = 31;

  localparam logic [1:0] KIND_MAP  = 2'd0;
  localparam logic [1:0] KIND_SCAN = 2'd1;
  localparam logic [1:0] KIND_RNG  = 2'd2;

  localparam logic [1:0] CLASS_FREE = 2'd0;
  localparam logic [1:0] CLASS_OBST = 2'd1;

  localparam logic [2:0] REG_RANGE_LOWER = 3'd0;
  localparam logic [2:0] REG_RANGE_UPPER = 3'd1;
  localparam logic [2:0] REG_ORIGIN_X    = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd3;
  localparam logic [2:0] REG_CPM         = 3'd4;
  localparam logic [2:0] REG_RADIUS      = 3'd5;
  localparam logic [2:0] REG_COLS        = 3'd6;
  localparam logic [2:0] REG_ROWS        = 3'd7;

  localparam logic [15:0] RANGE_GAIN = 16'd39797;

  function automatic logic [13:0] atan_lut(input logic [3:0] i);
    case (i)
      4'd0:    atan_lut = 14'd8192;
      4'd1:    atan_lut = 14'd4836;
      4'd2:    atan_lut = 14'd2555;
      4'd3:    atan_lut = 14'd1297;
      4'd4:    atan_lut = 14'd651;
      4'd5:    atan_lut = 14'd326;
      4'd6:    atan_lut = 14'd163;
      4'd7:    atan_lut = 14'd81;
      4'd8:    atan_lut = 14'd41;
      4'd9:    atan_lut = 14'd20;
      4'd10:   atan_lut = 14'd10;
      4'd11:   atan_lut = 14'd5;
      4'd12:   atan_lut = 14'd3;
      4'd13:   atan_lut = 14'd1;
      4'd14:   atan_lut = 14'd1;
      default: atan_lut = 14'd0;
    endcase
  endfunction

  typedef struct packed {
    logic map_wr;
    logic scan_ld;
    logic rng_ld;
    logic rot_init;
    logic rot_step;
    logic pose_add;
    logic mul_col;
    logic mul_row;
    logic cell_chk;
    logic win_init;
    logic win_step;
    logic commit;
  } spmcd_cmd_t;

  typedef struct packed {
    logic range_ok;
    logic rot_done;
    logic in_bounds;
    logic center_free;
    logic win_done;
    logic win_blocked;
  } spmcd_sts_t;

endpackage

[hdl/spmcd_datapath.sv]
`timescale 1ns / 1ps
module spmcd_datapath #(
  parameter int MAP_WIDTH  = spmcd_pkg::MapWidthDef,
  parameter int MAP_HEIGHT = spmcd_pkg::MapHeightDef,
  parameter int MAX_RADIUS = spmcd_pkg::MaxRadiusDef
) (
  input  logic                clk,
  input  logic                rst,
  input  spmcd_pkg::spmcd_cmd_t cmd,
  output spmcd_pkg::spmcd_sts_t sts,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                cfg_we,
  input  logic [8:0]          cell_col,
  input  logic [8:0]          cell_row,
  input  logic [1:0]          cell_class,
  input  logic signed [15:0]  pose_x,
  input  logic signed [15:0]  pose_y,
  input  logic [15:0]         pose_yaw,
  input  logic [15:0]         angle_start,
  input  logic [15:0]         angle_step,
  input  logic [15:0]         range_value,
  output logic                in_map,
  output logic [8:0]          hit_col,
  output logic [8:0]          hit_row,
  output logic                new_detection,
  output logic                cylinder_known,
  output logic [8:0]          cylinder_col,
  output logic [8:0]          cylinder_row
);
  import spmcd_pkg::*;

  localparam int CW = $clog2(MAP_WIDTH);
  localparam int RW = $clog2(MAP_HEIGHT);
  localparam int DW = (CW > RW ? CW : RW) + 2;

  logic [15:0] range_lower, range_upper;
  logic signed [15:0] origin_x, origin_y;
  logic [7:0] cpm;
  logic [4:0] clear_radius;
  logic [9:0] map_cols, map_rows;

  logic signed [15:0] held_pose_x, held_pose_y;
  logic [15:0] held_yaw, beam_angle, beam_step;
  logic found_flag;
  logic [8:0] found_col, found_row;

  logic [1:0] map_mem [2**(CW+RW)];
  logic [1:0] rd_data;
  logic [CW+RW-1:0] rd_addr;

  logic [15:0] range_q;
  logic signed [31:0] cx, cy;
  logic signed [16:0] cz;
  logic [3:0] it;
  logic signed [31:0] px, py;
  logic signed [31:0] col_w;
  logic [12:0] cols_lim, rows_lim;
  logic signed [DW-1:0] col_q, row_q;
  logic signed [DW-1:0] wdx, wdy, rad_s;
  logic in_b;
  logic win_blocked, win_done, center_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_lower <= '0;
      range_upper <= 16'd32767;
      origin_x <= -16'sd7680;
      origin_y <= -16'sd6144;
      cpm <= 8'd20;
      clear_radius <= 5'd10;
      map_cols <= 10'd512;
      map_rows <= 10'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_LOWER: range_lower <= cfg_data;
        REG_RANGE_UPPER: range_upper <= cfg_data;
        REG_ORIGIN_X:    origin_x <= cfg_data;
        REG_ORIGIN_Y:    origin_y <= cfg_data;
        REG_CPM:         cpm <= cfg_data[7:0];
        REG_RADIUS:      clear_radius <= cfg_data[4:0];
        REG_COLS:        map_cols <= cfg_data[9:0];
        REG_ROWS:        map_rows <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cols_lim = (13'(map_cols) > 13'(MAP_WIDTH)) ? 13'(MAP_WIDTH) : 13'(map_cols);
    rows_lim = (13'(map_rows) > 13'(MAP_HEIGHT)) ? 13'(MAP_HEIGHT) : 13'(map_rows);
    rad_s = (32'(clear_radius) > MAX_RADIUS) ? DW'(MAX_RADIUS) : DW'(clear_radius);
  end

  logic signed [DW+1:0] wc, wr;
  logic w_in;
  always_comb begin
    wc = (DW+2)'(col_q) + (DW+2)'(wdx);
    wr = (DW+2)'(row_q) + (DW+2)'(wdy);
    w_in = (wc >= 0) && (wc < $signed((DW+2)'(cols_lim))) &&
           (wr >= 0) && (wr < $signed((DW+2)'(rows_lim)));
    if (cmd.map_wr)
      rd_addr = {RW'(cell_row), CW'(cell_col)};
    else if (cmd.cell_chk)
      rd_addr = {row_q[RW-1:0], col_q[CW-1:0]};
    else
      rd_addr = {wr[RW-1:0], wc[CW-1:0]};
  end

  logic map_wr_ok;
  assign map_wr_ok = (32'(cell_col) < MAP_WIDTH) && (32'(cell_row) < MAP_HEIGHT);

  logic rd_in;
  always_ff @(posedge clk) begin
    if (cmd.map_wr && map_wr_ok) map_mem[rd_addr] <= cell_class;
    rd_data <= map_mem[rd_addr];
    rd_in <= w_in;
  end

  logic signed [31:0] xs, ys;
  assign xs = cx >>> it;
  assign ys = cy >>> it;

  logic [15:0] theta;
  logic signed [16:0] z0;
  assign theta = beam_angle + held_yaw;
  assign z0 = 17'(signed'(theta));

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_p;
  logic signed [40:0] prod;
  assign mul_a = cmd.mul_col ? px - 32'(origin_x) * 256 : -py - 32'(origin_y) * 256;
  assign prod = 41'(mul_a) * $signed({33'd0, cpm});
  assign mul_p = 32'(prod >>> 0 >= 0 ? (prod >>> 18) : -((-prod) >>> 18));

  logic wpend;
  always_ff @(posedge clk) begin
    if (rst) begin
      held_pose_x <= '0; held_pose_y <= '0; held_yaw <= '0;
      beam_angle <= '0; beam_step <= '0;
      found_flag <= 1'b0; found_col <= '0; found_row <= '0;
      in_map <= 1'b0; new_detection <= 1'b0; hit_col <= '0; hit_row <= '0;
      win_blocked <= 1'b0; win_done <= 1'b0; wpend <= 1'b0;
      it <= '0; in_b <= 1'b0;
    end else begin
      if (cmd.scan_ld) begin
        held_pose_x <= pose_x; held_pose_y <= pose_y; held_yaw <= pose_yaw;
        beam_angle <= angle_start; beam_step <= angle_step;
      end
      if (cmd.rng_ld) begin
        range_q <= range_value;
        in_b <= 1'b0;
      end
      if (cmd.rot_init) begin
        cx <= 32'((35'(range_q) * 35'(RANGE_GAIN)) >> 8);
        cy <= '0;
        it <= '0;
        if (z0 > 17'sd16384) begin
          cx <= -32'((35'(range_q) * 35'(RANGE_GAIN)) >> 8);
          cz <= z0 - 17'sd32768;
        end else if (z0 < -17'sd16384) begin
          cx <= -32'((35'(range_q) * 35'(RANGE_GAIN)) >> 8);
          cz <= z0 + 17'sd32768;
        end else cz <= z0;
      end
      if (cmd.rot_step) begin
        if (cz >= 0) begin
          cx <= cx - ys; cy <= cy + xs; cz <= cz - 17'(atan_lut(it));
        end else begin
          cx <= cx + ys; cy <= cy - xs; cz <= cz + 17'(atan_lut(it));
        end
        it <= it + 4'd1;
      end
      if (cmd.pose_add) begin
        px <= cx + 32'(held_pose_x) * 256;
        py <= cy + 32'(held_pose_y) * 256;
      end
      if (cmd.mul_col) col_w <= mul_p;
      if (cmd.mul_row) begin
        in_b <= (col_w >= 0) && (col_w < 32'(cols_lim)) &&
                (mul_p >= 0) && (mul_p < 32'(rows_lim));
        col_q <= DW'(col_w);
        row_q <= DW'(mul_p);
      end
      if (cmd.win_init) begin
        wdx <= -rad_s; wdy <= -rad_s;
        win_blocked <= 1'b0; win_done <= 1'b0; wpend <= 1'b0;
      end
      if (cmd.win_step) begin
        wpend <= !win_done;
        if (wpend && rd_in && rd_data == CLASS_OBST) win_blocked <= 1'b1;
        if (wdx == rad_s) begin
          wdx <= -rad_s;
          if (wdy == rad_s) win_done <= 1'b1; else wdy <= wdy + 1'b1;
        end else wdx <= wdx + 1'b1;
        if (win_done) wpend <= 1'b0;
      end
      if (cmd.commit) begin
        in_map <= in_b;
        hit_col <= in_b ? 9'(col_q) : 9'd0;
        hit_row <= in_b ? 9'(row_q) : 9'd0;
        new_detection <= 1'b0;
        if (in_b && center_free && !(win_blocked ||
            (wpend && rd_in && rd_data == CLASS_OBST)) && !found_flag) begin
          found_flag <= 1'b1; found_col <= 9'(col_q); found_row <= 9'(row_q);
          new_detection <= 1'b1;
        end
        beam_angle <= beam_angle + beam_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cell_chk) center_free <= 1'b0;
    if (cmd.win_init) center_free <= (rd_data == CLASS_FREE);
  end

  always_comb begin
    sts.range_ok = (range_value > range_lower) && (range_value < range_upper);
    sts.rot_done = (it == 4'd15) && cmd.rot_step;
    sts.in_bounds = in_b;
    sts.center_free = center_free;
    sts.win_done = win_done;
    sts.win_blocked = win_blocked;
  end

  assign cylinder_known = found_flag;
  assign cylinder_col = found_flag ? found_col : 9'd0;
  assign cylinder_row = found_flag ? found_row : 9'd0;
endmodule

[hdl/spmcd_ctrl.sv]
`timescale 1ns / 1ps
module spmcd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            kind,
  output logic                  out_valid,
  input  logic                  out_stall,
  output spmcd_pkg::spmcd_cmd_t cmd,
  input  spmcd_pkg::spmcd_sts_t sts
);
  import spmcd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ROT0, S_ROT, S_POSE, S_MCOL, S_MROW, S_CHK, S_WINIT, S_WIN,
    S_WLAST, S_COMMIT, S_OUT
  } state_t;

  state_t state;
  logic acc;

  assign in_stall = (state != S_IDLE);
  assign acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (acc && kind == KIND_RNG) state <= sts.range_ok ? S_ROT0 : S_COMMIT;
        S_ROT0: state <= S_ROT;
        S_ROT: if (sts.rot_done) state <= S_POSE;
        S_POSE: state <= S_MCOL;
        S_MCOL: state <= S_MROW;
        S_MROW: state <= S_CHK;
        S_CHK: state <= sts.in_bounds ? S_WINIT : S_COMMIT;
        S_WINIT: state <= S_WIN;
        S_WIN: if (sts.win_done) state <= S_WLAST;
        S_WLAST: state <= S_COMMIT;
        S_COMMIT: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.map_wr = acc && kind == KIND_MAP;
    cmd.scan_ld = acc && kind == KIND_SCAN;
    cmd.rng_ld = acc && kind == KIND_RNG;
    cmd.rot_init = (state == S_ROT0);
    cmd.rot_step = (state == S_ROT);
    cmd.pose_add = (state == S_POSE);
    cmd.mul_col = (state == S_MCOL);
    cmd.mul_row = (state == S_MROW);
    cmd.cell_chk = (state == S_CHK);
    cmd.win_init = (state == S_WINIT);
    cmd.win_step = (state == S_WIN) || (state == S_WLAST);
    cmd.commit = (state == S_COMMIT);
  end
endmodule

[hdl/scan_point_map_change_detector.sv]
`timescale 1ns / 1ps
// Scan point map change detector. Map writes and scan starts are taken while idle.
// A range item in range runs the 16-step shift-add rotator and, when its cell lies
// in the map, walks the obstacle window of radius r, (2r+1)^2 cells, through the
// single read port of the map memory; an item out of range goes straight to commit.
module scan_point_map_change_detector #(
  parameter int MAP_WIDTH  = spmcd_pkg::MapWidthDef,
  parameter int MAP_HEIGHT = spmcd_pkg::MapHeightDef,
  parameter int MAX_RADIUS = spmcd_pkg::MaxRadiusDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [8:0]         cell_col,
  input  logic [8:0]         cell_row,
  input  logic [1:0]         cell_class,
  input  logic signed [15:0] pose_x,
  input  logic signed [15:0] pose_y,
  input  logic [15:0]        pose_yaw,
  input  logic [15:0]        angle_start,
  input  logic [15:0]        angle_step,
  input  logic [15:0]        range_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               in_map,
  output logic [8:0]         hit_col,
  output logic [8:0]         hit_row,
  output logic               new_detection,
  output logic               cylinder_known,
  output logic [8:0]         cylinder_col,
  output logic [8:0]         cylinder_row,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import spmcd_pkg::*;

  spmcd_cmd_t cmd;
  spmcd_sts_t sts;

  assign cfg_ready = 1'b1;

  spmcd_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .kind, .out_valid, .out_stall, .cmd, .sts
  );

  spmcd_datapath #(
    .MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT), .MAX_RADIUS(MAX_RADIUS)
  ) u_dp (
    .clk, .rst, .cmd, .sts, .cfg_index, .cfg_data,
    .cfg_we(cfg_valid && cfg_ready),
    .cell_col, .cell_row, .cell_class, .pose_x, .pose_y, .pose_yaw,
    .angle_start, .angle_step, .range_value,
    .in_map, .hit_col, .hit_row, .new_detection, .cylinder_known,
    .cylinder_col, .cylinder_row
  );

  a_newdet_known: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_detection |-> cylinder_known && in_map)
    else $error("detection without latch");
  a_newdet_once: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && new_detection |-> !$past(cylinder_known))
    else $error("second detection");
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
endmodule
